// ===== rtl/core/cmtm_pkg.sv =====
`timescale 1ns / 1ps
package cmtm_pkg;

  localparam int SLOTS = 16;
  localparam int TICK_PERIOD_MS = 10;
  localparam int MAX_RESULTS = 16;

  localparam int ID_W = 29;
  localparam int TMO_W = 16;
  localparam int CNT_W = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // The limit is timeout_ms / TICK_PERIOD_MS, done as a multiply by a rounded-up
  // reciprocal, which is exact for every 16-bit dividend.
  localparam int DIV_SHIFT = TMO_W + $clog2(TICK_PERIOD_MS);
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SHIFT) + TICK_PERIOD_MS - 1) / TICK_PERIOD_MS;
  localparam int RECIP_W = TMO_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];
  localparam int PROD_W = TMO_W + RECIP_W;

  localparam logic [1:0] CMD_REG = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef enum logic [1:0] {
    EV_LOST = 2'd0,
    EV_RESTORED = 2'd1,
    EV_REG_OK = 2'd2,
    EV_FULL = 2'd3
  } event_t;

  typedef struct packed {
    logic load;
    logic look_adv;
    logic apply;
    logic tick_step;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] req_cmd;
    logic cur_valid;
    logic cur_match;
    logic idx_last;
    logic tick_block;
    logic apply_out;
    logic out_free;
    logic pend_valid;
  } dp_status_t;

endpackage

// ===== rtl/core/cmtm_ctrl.sv =====
`timescale 1ns / 1ps
module cmtm_ctrl
  import cmtm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  ctrl
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_APPLY = 5'b00100,
    S_TICK  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOOK: begin
        if (status.cur_match || !status.cur_valid || status.idx_last) begin
          state_next = S_APPLY;
        end else begin
          ctrl.look_adv = 1'b1;
        end
      end
      S_APPLY: begin
        if (!status.apply_out || status.out_free) begin
          ctrl.apply = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (!status.cur_valid) begin
          state_next = S_FLUSH;
        end else if (!status.tick_block) begin
          ctrl.tick_step = 1'b1;
          if (status.idx_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          ctrl.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (state == S_IDLE && in_valid) begin
      case (status.req_cmd)
        CMD_REG, CMD_FRAME: state_next = S_LOOK;
        CMD_TICK: state_next = S_TICK;
        default: state_next = S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/cmtm_datapath.sv =====
`timescale 1ns / 1ps
module cmtm_datapath
  import cmtm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         ctrl,
  output dp_status_t        status,
  input  logic [1:0]        cmd,
  input  logic [ID_W-1:0]   can_id,
  input  logic [TMO_W-1:0]  timeout_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_res,
  output logic [ID_W-1:0]   event_id,
  output logic              last
);

  logic [1:0]        req_cmd;
  logic [ID_W-1:0]   req_id;
  logic [CNT_W-1:0]  req_lim;
  logic [SLOT_W-1:0] idx;
  logic [NRES_W-1:0] nres;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;

  logic              slot_valid [SLOTS];
  logic [ID_W-1:0]   slot_id    [SLOTS];
  logic [CNT_W-1:0]  slot_limit [SLOTS];
  logic [CNT_W-1:0]  slot_count [SLOTS];
  logic              slot_lost  [SLOTS];

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;
  logic              cur_valid;
  logic              cur_match;
  logic [CNT_W-1:0]  cnt_inc;
  logic              tick_hit;
  logic              nres_room;
  logic              out_free;
  logic              apply_out;
  logic              tick_emit;
  logic              out_load;

  assign prod = PROD_W'(timeout_ms) * PROD_W'(RECIP);
  assign quot = prod >> DIV_SHIFT;

  assign cur_valid = slot_valid[idx];
  assign cur_match = cur_valid && (slot_id[idx] == req_id);
  assign cnt_inc = (slot_count[idx] == CNT_MAX) ? slot_count[idx] : slot_count[idx] + 1'b1;
  assign tick_hit = cnt_inc >= slot_limit[idx];
  assign nres_room = nres < NRES_W'(MAX_RESULTS);
  assign out_free = !out_valid || !out_stall;
  assign apply_out = (req_cmd == CMD_REG) || (cur_match && slot_lost[idx]);
  assign tick_emit = tick_hit && nres_room && pend_valid;
  assign out_load = (ctrl.apply && apply_out) || (ctrl.tick_step && tick_emit) || ctrl.flush;

  always_comb begin
    status.req_cmd = ctrl.load ? cmd : req_cmd;
    status.cur_valid = cur_valid;
    status.cur_match = cur_match;
    status.idx_last = (idx == SLOT_W'(SLOTS - 1));
    status.tick_block = tick_emit && !out_free;
    status.apply_out = apply_out;
    status.out_free = out_free;
    status.pend_valid = pend_valid;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_cmd <= cmd;
      req_id <= can_id;
      req_lim <= quot[CNT_W-1:0];
    end
    if (ctrl.tick_step && tick_hit && nres_room) begin
      pend_id <= slot_id[idx];
    end
    if (ctrl.apply && (req_cmd == CMD_REG) && !cur_valid) begin
      slot_id[idx] <= req_id;
    end
    if (ctrl.apply && (req_cmd == CMD_REG) && (cur_match || !cur_valid)) begin
      slot_limit[idx] <= req_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      nres <= '0;
      pend_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_count[i] <= '0;
        slot_lost[i] <= 1'b0;
      end
    end else begin
      if (ctrl.load) begin
        idx <= '0;
        nres <= '0;
        pend_valid <= 1'b0;
      end
      if (ctrl.look_adv) begin
        idx <= idx + 1'b1;
      end
      if (ctrl.apply) begin
        if (req_cmd == CMD_REG) begin
          if (cur_match) begin
            slot_count[idx] <= '0;
          end else if (!cur_valid) begin
            slot_valid[idx] <= 1'b1;
            slot_count[idx] <= '0;
            slot_lost[idx] <= 1'b0;
          end
        end else if (req_cmd == CMD_FRAME && cur_match) begin
          slot_count[idx] <= '0;
          slot_lost[idx] <= 1'b0;
        end
      end
      if (ctrl.tick_step) begin
        slot_count[idx] <= cnt_inc;
        idx <= idx + 1'b1;
        if (tick_hit) begin
          slot_lost[idx] <= 1'b1;
          if (nres_room) begin
            pend_valid <= 1'b1;
            nres <= nres + 1'b1;
          end
        end
      end
      if (ctrl.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply && apply_out) begin
      last <= 1'b1;
      event_id <= req_id;
      if (req_cmd != CMD_REG) begin
        event_res <= EV_RESTORED;
      end else if (cur_match || !cur_valid) begin
        event_res <= EV_REG_OK;
      end else begin
        event_res <= EV_FULL;
      end
    end else if (ctrl.tick_step && tick_emit) begin
      last <= 1'b0;
      event_id <= pend_id;
      event_res <= EV_LOST;
    end else if (ctrl.flush) begin
      last <= 1'b1;
      event_id <= pend_id;
      event_res <= EV_LOST;
    end
  end

endmodule

// ===== rtl/core/can_message_timeout_monitor_unit.sv =====
`timescale 1ns / 1ps
// Supervises up to SLOTS watched CAN identifiers for silence.
// Input channel: in_valid/in_stall carry one item of cmd, can_id and timeout_ms.
// cmd selects a register item, a tick of the monitor period or a received frame.
// Output channel: out_valid/out_stall carry event_res and event_id; last is set on
// the final result that an item causes. Ticks and frames may cause no result.
// A register or frame item searches the slot table one entry per cycle, then the
// matching entry, or for a register the first free one, is updated.
// A tick item updates each valid slot's counter in turn, and every lost report is
// held until the next one or the end of the scan so that last can be marked.
// A new item is accepted only once the previous one has finished its scan.
// Results leave through an output register; the next item is accepted while a
// finished result is still waiting. When the receiver stalls, a scan that must
// emit another result waits until the output register is taken.
// Reset empties the table, clears every counter and lost flag, and drops any
// result that has not been taken.
module can_message_timeout_monitor_unit
  import cmtm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [ID_W-1:0]   can_id,
  input  logic [TMO_W-1:0]  timeout_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_res,
  output logic [ID_W-1:0]   event_id,
  output logic              last
);

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  cmtm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctrl     (ctrl)
  );

  cmtm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .cmd        (cmd),
    .can_id     (can_id),
    .timeout_ms (timeout_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .event_id   (event_id),
    .last       (last)
  );

endmodule

// ===== dv/can_message_timeout_monitor_checker.sv =====
`timescale 1ns / 1ps
module can_message_timeout_monitor_checker
  import cmtm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       cmd,
  input  logic [ID_W-1:0]  can_id,
  input  logic [TMO_W-1:0] timeout_ms,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       event_res,
  input  logic [ID_W-1:0]  event_id,
  input  logic             last,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    event_t          res;
    logic [ID_W-1:0] id;
    logic            is_last;
  } monitor_event_t;

  logic             slot_used  [SLOTS];
  logic [ID_W-1:0]  slot_ident [SLOTS];
  logic [CNT_W-1:0] slot_lim   [SLOTS];
  logic [CNT_W-1:0] slot_cnt   [SLOTS];
  logic             slot_lost  [SLOTS];
  monitor_event_t   expected_events [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int find_ident(input logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_ident[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic predict_events(input logic [1:0] op, input logic [ID_W-1:0] id,
                                input logic [TMO_W-1:0] tmo);
    monitor_event_t   batch [MAX_RESULTS];
    logic [CNT_W-1:0] lim;
    int               n;
    int               s;
    n = 0;
    lim = CNT_W'(tmo / TICK_PERIOD_MS);
    case (op)
      CMD_REG: begin
        s = find_ident(id);
        if (s < 0) begin
          s = 0;
          while (s < SLOTS && slot_used[s]) s++;
          if (s < SLOTS) begin
            slot_used[s] = 1'b1;
            slot_ident[s] = id;
            slot_lost[s] = 1'b0;
          end
        end
        if (s < SLOTS) begin
          slot_cnt[s] = '0;
          slot_lim[s] = lim;
          batch[0] = '{EV_REG_OK, id, 1'b0};
        end else begin
          batch[0] = '{EV_FULL, id, 1'b0};
        end
        n = 1;
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) begin
            if (slot_cnt[i] != CNT_MAX) slot_cnt[i] = slot_cnt[i] + 1'b1;
            if (slot_cnt[i] >= slot_lim[i]) begin
              slot_lost[i] = 1'b1;
              if (n < MAX_RESULTS) begin
                batch[n] = '{EV_LOST, slot_ident[i], 1'b0};
                n++;
              end
            end
          end
        end
      end
      CMD_FRAME: begin
        s = find_ident(id);
        if (s >= 0) begin
          slot_cnt[s] = '0;
          if (slot_lost[s]) begin
            slot_lost[s] = 1'b0;
            batch[0] = '{EV_RESTORED, slot_ident[s], 1'b0};
            n = 1;
          end
        end
      end
      default: begin
      end
    endcase
    if (n > 0) batch[n-1].is_last = 1'b1;
    for (int k = 0; k < n; k++) expected_events.push_back(batch[k]);
  endtask

  task automatic check_event();
    monitor_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event res=%0d id=%h last=%0b",
                                event_res, event_id, last));
    end else begin
      want = expected_events.pop_front();
      if (event_res !== want.res)
        report_mismatch($sformatf("event_res %0d, expected %0d", event_res, want.res));
      if (event_id !== want.id)
        report_mismatch($sformatf("event_id %h, expected %h", event_id, want.id));
      if (last !== want.is_last)
        report_mismatch($sformatf("last %0b, expected %0b", last, want.is_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_cnt[i] = '0;
        slot_lost[i] = 1'b0;
      end
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall) check_event();
      if (in_valid && !in_stall) predict_events(cmd, can_id, timeout_ms);
    end
    pending <= expected_events.size();
  end

endmodule

// ===== dv/tb_can_message_timeout_monitor_unit.sv =====
`timescale 1ns / 1ps
module tb_can_message_timeout_monitor_unit;
  import cmtm_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       cmd = CMD_NONE;
  logic [ID_W-1:0]  can_id = '0;
  logic [TMO_W-1:0] timeout_ms = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       event_res;
  logic [ID_W-1:0]  event_id;
  logic             last;
  int               fail_count;
  int               pending;
  int               send_idle_pct = 22;
  int               recv_idle_pct = 62;
  logic             hold_go = 1'b0;
  logic             hold_used = 1'b0;
  int               hold_left = 0;
  logic [ID_W-1:0]  known_ids [$];

  always #1 clk = ~clk;

  can_message_timeout_monitor_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .can_id     (can_id),
    .timeout_ms (timeout_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .event_id   (event_id),
    .last       (last)
  );

  can_message_timeout_monitor_checker monitor_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .can_id     (can_id),
    .timeout_ms (timeout_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .event_id   (event_id),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver stalls at random, and once holds off for a long stretch so
  // that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [ID_W-1:0] id,
                           input logic [TMO_W-1:0] tmo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    can_id <= id;
    timeout_ms <= tmo;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [ID_W-1:0] id;
    int              sent;
    int              pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_REG, '0, 16'd0);
    send_item(CMD_REG, 29'h1FFFFFFF, 16'hFFFF);
    send_item(CMD_REG, 29'h0ABCDEF, 16'd25);
    send_item(CMD_REG, '0, 16'd9);
    send_item(CMD_NONE, 29'h1FFFFFFF, 16'hFFFF);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, 29'h1FFFFFFF, 16'hFFFF);
    send_item(CMD_FRAME, 29'h0ABCDEF, '0);
    send_item(CMD_FRAME, 29'h0ABCDEF, 16'hFFFF);
    send_item(CMD_FRAME, 29'h1234567, '0);
    send_item(CMD_REG, '0, 16'd30);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_FRAME, '0, '0);
    known_ids.push_back('0);
    known_ids.push_back(29'h1FFFFFFF);
    known_ids.push_back(29'h0ABCDEF);
    while (known_ids.size() < SLOTS) begin
      id = ID_W'($urandom);
      send_item(CMD_REG, id, TMO_W'($urandom_range(0, 50)));
      known_ids.push_back(id);
    end
    send_item(CMD_REG, 29'h15555555, 16'hAAAA);

    sent = 0;
    while (sent < 100) begin
      if (sent == 34) begin
        send_idle_pct <= 62;
        recv_idle_pct <= 22;
      end
      if (sent == 67 && !hold_go) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_go <= 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(CMD_NONE, ID_W'($urandom), TMO_W'($urandom));
      end else begin
        if (pick < 40)
          send_item(CMD_TICK, ID_W'($urandom), TMO_W'($urandom));
        else if (pick < 75)
          send_item(CMD_FRAME, known_ids[$urandom_range(0, known_ids.size() - 1)],
                    TMO_W'($urandom));
        else if (pick < 80)
          send_item(CMD_FRAME, ID_W'($urandom), TMO_W'($urandom));
        else if (pick < 93)
          send_item(CMD_REG, known_ids[$urandom_range(0, known_ids.size() - 1)],
                    TMO_W'((pick < 90) ? $urandom_range(0, 60) : $urandom_range(0, 65535)));
        else
          send_item(CMD_REG, ID_W'($urandom), TMO_W'($urandom));
        sent++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_can_message_timeout_monitor_unit passed");
    end else begin
      $display("tb_can_message_timeout_monitor_unit failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_can_message_timeout_monitor_unit failed");
    $finish;
  end

endmodule
